// ===== hdl/wpnr_pkg.sv =====
// Shared types and constants for the waveform peak and noise RMS core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps
`default_nettype none

package wpnr_pkg;

   localparam int ADC_BITS    = 14;
   localparam int TICK_W      = 13;
   localparam int MAX_TICKS   = 8192;
   localparam int CFG_W       = 18;     // widest register
   localparam int CSR_IDX_W   = 2;
   localparam int SAMPLE_W    = 19;     // pedestal-subtracted sample, Q4, signed
   localparam int MAG_W       = 18;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = 50;
   localparam int CNT_W       = 14;
   localparam int COUNT_MAX   = 16383;
   localparam int RMS_W       = 18;
   localparam int DIV_STEPS   = SUM_W;
   localparam int ROOT_STEPS  = SUM_W / 2;
   localparam int STEP_W      = 6;
   localparam int THR_RESET   = 640;    // forty counts in Q4

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PEDESTAL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_START = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROI_END   = 2'd3;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_DRAIN,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;      // input word taken this cycle
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic load_rsp;    // copy result into output register
      logic clear_wave;  // reset per-waveform accumulators
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;   // sample pipeline still holds words
      logic rsp_busy;    // output register full and stalled
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/wpnr_ctrl.sv =====
// Controller state machine: sample intake, drain, divide, root, result.
// Depends on wpnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpnr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last_sample,
   input  wire wpnr_pkg::stat_type stat,
   output wpnr_pkg::cmd_type      cmd,
   output logic                   req_stall
);

   wpnr_pkg::ctrl_state_type state_ff, state_in;
   logic [wpnr_pkg::STEP_W-1:0] step_ff, step_in;
   logic div_last, root_last;

   assign div_last  = (step_ff == wpnr_pkg::STEP_W'(wpnr_pkg::DIV_STEPS - 1));
   assign root_last = (step_ff == wpnr_pkg::STEP_W'(wpnr_pkg::ROOT_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpnr_pkg::ST_RUN;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         wpnr_pkg::ST_RUN: begin
            if (req_valid && req_last_sample) state_in = wpnr_pkg::ST_DRAIN;
         end
         wpnr_pkg::ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = wpnr_pkg::ST_DIV;
         end
         wpnr_pkg::ST_DIV: begin
            if (div_last) state_in = wpnr_pkg::ST_ROOT_LOAD;
            else step_in = step_ff + 1'b1;
         end
         wpnr_pkg::ST_ROOT_LOAD: begin
            state_in = wpnr_pkg::ST_ROOT;
         end
         wpnr_pkg::ST_ROOT: begin
            if (root_last) state_in = wpnr_pkg::ST_DONE;
            else step_in = step_ff + 1'b1;
         end
         wpnr_pkg::ST_DONE: begin
            if (!stat.rsp_busy) state_in = wpnr_pkg::ST_RUN;
         end
         default: state_in = wpnr_pkg::ST_RUN;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         wpnr_pkg::ST_RUN: begin
            req_stall  = reset;
            cmd.accept = req_valid && !reset;
         end
         wpnr_pkg::ST_DRAIN: begin
            cmd.div_load = !stat.pipe_busy;
         end
         wpnr_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         wpnr_pkg::ST_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
         end
         wpnr_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         wpnr_pkg::ST_DONE: begin
            cmd.load_rsp   = !stat.rsp_busy;
            cmd.clear_wave = !stat.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/wpnr_divsqrt.sv =====
// Iterative unit: restoring divide of the square sum by the count (one bit a
// cycle), then digit-by-digit integer square root in place (one digit a cycle).
// Depends on wpnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpnr_divsqrt (
   input  wire logic                         clock,
   input  wire wpnr_pkg::cmd_type            cmd,
   input  wire logic [wpnr_pkg::SUM_W-1:0]   square_sum,
   input  wire logic [wpnr_pkg::CNT_W-1:0]   square_count,
   output logic      [wpnr_pkg::RMS_W-1:0]   root
);

   localparam logic [wpnr_pkg::SUM_W-1:0] ROOT_TOP =
      wpnr_pkg::SUM_W'(1) << (2 * (wpnr_pkg::ROOT_STEPS - 1));

   logic [wpnr_pkg::SUM_W-1:0] work_ff, work_in;   // quotient, then root remainder
   logic [wpnr_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [wpnr_pkg::SUM_W-1:0] res_ff, res_in;
   logic [wpnr_pkg::SUM_W-1:0] bit_ff, bit_in;
   logic [wpnr_pkg::CNT_W:0]   rem_shift;
   logic [wpnr_pkg::CNT_W:0]   rem_diff;
   logic [wpnr_pkg::SUM_W-1:0] trial;

   assign rem_shift = {rem_ff, work_ff[wpnr_pkg::SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, square_count};
   assign trial     = res_ff + bit_ff;

   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (cmd.div_load) begin
         work_in = square_sum;
         rem_in  = '0;
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, square_count}) begin
            rem_in  = rem_diff[wpnr_pkg::CNT_W-1:0];
            work_in = {work_ff[wpnr_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[wpnr_pkg::CNT_W-1:0];
            work_in = {work_ff[wpnr_pkg::SUM_W-2:0], 1'b0};
         end
      end else if (cmd.root_load) begin
         res_in = '0;
         bit_in = ROOT_TOP;
      end else if (cmd.root_step) begin
         if (work_ff >= trial) begin
            work_in = work_ff - trial;
            res_in  = (res_ff >> 1) + bit_ff;
         end else begin
            res_in  = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
   end

   assign root = res_ff[wpnr_pkg::RMS_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/wpnr_datapath.sv =====
// Datapath: configuration registers, three-stage sample pipeline (subtract and
// classify, square, accumulate), peak tracker and the output register.
// Depends on wpnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpnr_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire wpnr_pkg::cmd_type               cmd,
   output wpnr_pkg::stat_type                   stat,
   input  wire logic [wpnr_pkg::ADC_BITS-1:0]   req_adc_sample,
   input  wire logic                            req_last_sample,
   input  wire logic                            csr_write_en,
   input  wire logic [wpnr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wpnr_pkg::CFG_W-1:0]      csr_wdata,
   input  wire logic [wpnr_pkg::RMS_W-1:0]      root,
   output logic      [wpnr_pkg::SUM_W-1:0]      square_sum,
   output logic      [wpnr_pkg::CNT_W-1:0]      square_count,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [wpnr_pkg::SAMPLE_W-1:0] rsp_peak_amplitude_q4,
   output logic      [wpnr_pkg::TICK_W-1:0]     rsp_peak_tick,
   output logic                                 rsp_peak_found,
   output logic      [wpnr_pkg::RMS_W-1:0]      rsp_noise_rms_q4,
   output logic      [wpnr_pkg::CNT_W-1:0]      rsp_noise_count,
   output logic                                 rsp_noise_valid
);

   localparam logic [wpnr_pkg::TICK_W-1:0] TICK_LAST =
      wpnr_pkg::TICK_W'(wpnr_pkg::MAX_TICKS - 1);
   localparam logic [wpnr_pkg::CNT_W-1:0] CNT_FULL =
      wpnr_pkg::CNT_W'(wpnr_pkg::COUNT_MAX);

   // configuration
   logic [wpnr_pkg::CFG_W-1:0]  pedestal_ff, threshold_ff;
   logic [wpnr_pkg::TICK_W-1:0] roi_start_ff, roi_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pedestal_ff  <= '0;
         threshold_ff <= wpnr_pkg::CFG_W'(wpnr_pkg::THR_RESET);
         roi_start_ff <= '0;
         roi_end_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            wpnr_pkg::REG_PEDESTAL:  pedestal_ff  <= csr_wdata;
            wpnr_pkg::REG_THRESHOLD: threshold_ff <= csr_wdata;
            wpnr_pkg::REG_ROI_START: roi_start_ff <= csr_wdata[wpnr_pkg::TICK_W-1:0];
            wpnr_pkg::REG_ROI_END:   roi_end_ff   <= csr_wdata[wpnr_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1 input registers
   logic                          s1_valid_ff;
   logic [wpnr_pkg::ADC_BITS-1:0] s1_raw_ff;
   logic                          s1_last_ff;
   logic [wpnr_pkg::TICK_W-1:0]   s1_tick_ff;
   logic [wpnr_pkg::TICK_W-1:0]   tick_ff;

   // stage 2 / 3
   logic                          s2_valid_ff, s2_add_ff;
   logic [wpnr_pkg::MAG_W-1:0]    s2_mag_ff;
   logic                          s3_valid_ff, s3_add_ff;
   logic [wpnr_pkg::SQ_W-1:0]     s3_sq_ff;

   // per-waveform state
   logic signed [wpnr_pkg::SAMPLE_W-1:0] peak_value_ff;
   logic [wpnr_pkg::TICK_W-1:0]          peak_pos_ff;
   logic                                 peak_seen_ff;
   logic [wpnr_pkg::SUM_W-1:0]           sum_ff;
   logic [wpnr_pkg::CNT_W-1:0]           count_ff;

   // stage 1 logic
   logic signed [wpnr_pkg::SAMPLE_W-1:0] s1_value;
   logic [wpnr_pkg::MAG_W-1:0]           s1_mag;
   logic s1_in_roi, s1_interior, s1_noise, s1_take_peak;

   assign s1_value = $signed({1'b0, s1_raw_ff, 4'b0000}) - $signed({1'b0, pedestal_ff});
   assign s1_mag   = s1_value[wpnr_pkg::SAMPLE_W-1] ?
                     wpnr_pkg::MAG_W'(-s1_value) : s1_value[wpnr_pkg::MAG_W-1:0];
   assign s1_in_roi   = (s1_tick_ff >= roi_start_ff) && (s1_tick_ff <= roi_end_ff);
   assign s1_interior = (s1_tick_ff > roi_start_ff) && (s1_tick_ff < roi_end_ff) &&
                        !s1_last_ff;
   assign s1_noise    = !s1_interior && (s1_mag <= threshold_ff) && (count_ff < CNT_FULL);
   assign s1_take_peak = s1_in_roi && (!peak_seen_ff || (s1_value > peak_value_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         tick_ff     <= '0;
      end else begin
         s1_valid_ff <= cmd.accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (cmd.clear_wave) tick_ff <= '0;
         else if (cmd.accept && (tick_ff != TICK_LAST)) tick_ff <= tick_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_raw_ff  <= req_adc_sample;
         s1_last_ff <= req_last_sample;
         s1_tick_ff <= tick_ff;
      end
      s2_mag_ff <= s1_mag;
      s2_add_ff <= s1_valid_ff && s1_noise;
      s3_sq_ff  <= s2_mag_ff * s2_mag_ff;
      s3_add_ff <= s2_valid_ff && s2_add_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_wave) begin
         peak_value_ff <= '0;
         peak_pos_ff   <= '0;
         peak_seen_ff  <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
      end else begin
         if (s1_valid_ff && s1_take_peak) begin
            peak_value_ff <= s1_value;
            peak_pos_ff   <= s1_tick_ff;
            peak_seen_ff  <= 1'b1;
         end
         if (s1_valid_ff && s1_noise) count_ff <= count_ff + 1'b1;
         if (s3_valid_ff && s3_add_ff)
            sum_ff <= sum_ff + wpnr_pkg::SUM_W'(s3_sq_ff);
      end
   end

   assign square_sum   = sum_ff;
   assign square_count = count_ff;

   // output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_peak_amplitude_q4 <= peak_value_ff;
         rsp_peak_tick         <= peak_pos_ff;
         rsp_peak_found        <= peak_seen_ff;
         rsp_noise_rms_q4      <= (count_ff == '0) ? '0 : root;
         rsp_noise_count       <= count_ff;
         rsp_noise_valid       <= (count_ff != '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign stat.pipe_busy = s1_valid_ff || s2_valid_ff || s3_valid_ff;
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;

endmodule

`default_nettype wire

// ===== hdl/waveform_peak_and_noise_rms_core.sv =====
// Top level of the waveform peak finder with noise RMS.
// Depends on wpnr_pkg, wpnr_ctrl, wpnr_datapath and wpnr_divsqrt.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  req      | req_valid / req_stall | adc_sample[13:0], last_sample
//  rsp      | rsp_valid / rsp_stall | peak_amplitude_q4, peak_tick, peak_found,
//           |                       | noise_rms_q4, noise_count, noise_valid
//  csr      | csr_write_en          | csr_index[1:0], csr_wdata[17:0]
//
// Samples are taken one word per cycle while the waveform runs; a sample
// passes a three-stage pipeline (subtract/classify, square, accumulate).
// After the last sample the input stalls while the core drains the pipeline and
// loads the divider, runs the bit-serial divide, loads and runs the square root
// and loads the result word once the output register is free.
// A finished result waits in the output register; the next waveform can start
// as soon as it is loaded. A result is loaded only when that register is free
// or being taken. Reset is synchronous and holds req_stall high.
`timescale 1ns / 1ps
`default_nettype none

module waveform_peak_and_noise_rms_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input words
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [wpnr_pkg::ADC_BITS-1:0]   req_adc_sample,
   input  wire logic                            req_last_sample,
   // result words
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [wpnr_pkg::SAMPLE_W-1:0] rsp_peak_amplitude_q4,
   output logic      [wpnr_pkg::TICK_W-1:0]     rsp_peak_tick,
   output logic                                 rsp_peak_found,
   output logic      [wpnr_pkg::RMS_W-1:0]      rsp_noise_rms_q4,
   output logic      [wpnr_pkg::CNT_W-1:0]      rsp_noise_count,
   output logic                                 rsp_noise_valid,
   // register writes
   input  wire logic                            csr_write_en,
   input  wire logic [wpnr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wpnr_pkg::CFG_W-1:0]      csr_wdata
);

   wpnr_pkg::cmd_type  cmd;
   wpnr_pkg::stat_type stat;

   logic [wpnr_pkg::SUM_W-1:0] square_sum;
   logic [wpnr_pkg::CNT_W-1:0] square_count;
   logic [wpnr_pkg::RMS_W-1:0] root;

   // sequencing: intake, drain, divide, root, result load
   wpnr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_sample (req_last_sample),
      .stat            (stat),
      .cmd             (cmd),
      .req_stall       (req_stall)
   );

   // sample pipeline, accumulators, registers, output word
   wpnr_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_adc_sample        (req_adc_sample),
      .req_last_sample       (req_last_sample),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .root                  (root),
      .square_sum            (square_sum),
      .square_count          (square_count),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_peak_amplitude_q4 (rsp_peak_amplitude_q4),
      .rsp_peak_tick         (rsp_peak_tick),
      .rsp_peak_found        (rsp_peak_found),
      .rsp_noise_rms_q4      (rsp_noise_rms_q4),
      .rsp_noise_count       (rsp_noise_count),
      .rsp_noise_valid       (rsp_noise_valid)
   );

   // mean square and root, one bit / one digit per cycle
   wpnr_divsqrt u_divsqrt (
      .clock        (clock),
      .cmd          (cmd),
      .square_sum   (square_sum),
      .square_count (square_count),
      .root         (root)
   );

endmodule

`default_nettype wire

// ===== hdl/wpnr_checker.sv =====
// Port-level checks for the waveform peak and noise RMS core, bound to the top.
// Depends on wpnr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpnr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            req_last_sample,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic signed [wpnr_pkg::SAMPLE_W-1:0] rsp_peak_amplitude_q4,
   input wire logic [wpnr_pkg::TICK_W-1:0]     rsp_peak_tick,
   input wire logic                            rsp_peak_found,
   input wire logic [wpnr_pkg::RMS_W-1:0]      rsp_noise_rms_q4,
   input wire logic [wpnr_pkg::CNT_W-1:0]      rsp_noise_count,
   input wire logic                            rsp_noise_valid
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_peak_amplitude_q4) &&
      $stable(rsp_peak_tick) && $stable(rsp_noise_rms_q4) && $stable(rsp_noise_count))
      else $error("result word changed while stalled");

   // the last sample of a waveform starts the closing sequence
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_sample |=> req_stall)
      else $error("input not stalled after last sample");

   // a new result is only loaded while input is held off
   a_rsp_after_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without closing sequence");

   a_empty_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_peak_found |-> rsp_peak_amplitude_q4 == '0 && rsp_peak_tick == '0)
      else $error("empty region reports a peak");

   a_no_noise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_noise_valid |-> rsp_noise_rms_q4 == '0 && rsp_noise_count == '0)
      else $error("invalid noise figure not zero");

endmodule

bind waveform_peak_and_noise_rms_core wpnr_checker u_wpnr_checker (.*);

`default_nettype wire

// ===== sim/tb_waveform_peak_and_noise_rms_core.sv =====
// Self-checking testbench for waveform_peak_and_noise_rms_core.
// Needs wpnr_pkg and the core RTL; carries its own per-waveform predictor.
`timescale 1ns / 1ps

module tb_waveform_peak_and_noise_rms_core;
   import wpnr_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 2000000;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int LATENCY_CYCLES = 100;   // drain + divide + root + load, with margin
   localparam int ADC_MAX        = (1 << ADC_BITS) - 1;
   localparam int CFG_MAX        = (1 << CFG_W) - 1;
   localparam int TICK_MAX       = MAX_TICKS - 1;

   // One result word, as the block reports it.
   typedef struct {
      logic signed [SAMPLE_W-1:0] amp;
      logic        [TICK_W-1:0]   tick;
      logic                       found;
      logic        [RMS_W-1:0]    rms;
      logic        [CNT_W-1:0]    count;
      logic                       valid;
   } wave_summary_type;

   // Floor of the square root, built one result bit at a time from the top.
   function automatic longint unsigned floor_root(longint unsigned val);
      longint unsigned root;
      longint unsigned trial;
      int              b;
      root = 0;
      for (b = 25; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= val)
            root = trial;
      end
      return root;
   endfunction

   // Tracks peak and noise sums per waveform and holds the summaries still owed.
   class wave_scoreboard;
      logic [CFG_W-1:0]  pedestal;
      logic [CFG_W-1:0]  threshold;
      logic [TICK_W-1:0] region_first;
      logic [TICK_W-1:0] region_last;

      int unsigned       tick;
      int                peak;
      int unsigned       peak_at;
      bit                peak_seen;
      longint unsigned   square_sum;
      int unsigned       square_count;

      wave_summary_type  owed_q[$];
      int                errors;
      int                samples;
      int                waves;
      int                checked;

      function new();
         pedestal     = '0;
         threshold    = CFG_W'(THR_RESET);
         region_first = '0;
         region_last  = '0;
         errors       = 0;
         samples      = 0;
         waves        = 0;
         checked      = 0;
         restart();
      endfunction

      function void restart();
         tick         = 0;
         peak         = 0;
         peak_at      = 0;
         peak_seen    = 0;
         square_sum   = 0;
         square_count = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_PEDESTAL:  pedestal     = value;
            REG_THRESHOLD: threshold    = value;
            REG_ROI_START: region_first = value[TICK_W-1:0];
            REG_ROI_END:   region_last  = value[TICK_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [ADC_BITS-1:0] adc, logic last);
         int               level;
         int unsigned      abs_level;
         longint unsigned  mag;
         bit               in_region;
         bit               inner;
         wave_summary_type s;
         level     = 16 * int'(adc) - int'(pedestal);
         abs_level = (level < 0) ? -level : level;
         mag       = abs_level;
         in_region = (tick >= region_first) && (tick <= region_last);
         // boundary ticks and the final tick are never inner, so they feed noise too
         inner     = (tick > region_first) && (tick < region_last) && !last;
         samples++;

         if (in_region && (!peak_seen || level > peak)) begin
            peak      = level;
            peak_at   = tick;
            peak_seen = 1;
         end
         if (!inner && mag <= threshold && square_count < COUNT_MAX) begin
            square_sum += mag * mag;
            square_count++;
         end
         if (tick < TICK_MAX)
            tick++;

         if (last) begin
            s.amp   = peak_seen ? peak[SAMPLE_W-1:0] : '0;
            s.tick  = peak_seen ? peak_at[TICK_W-1:0] : '0;
            s.found = peak_seen;
            s.rms   = (square_count != 0) ?
                      RMS_W'(floor_root(square_sum / square_count)) : '0;
            s.count = square_count[CNT_W-1:0];
            s.valid = (square_count != 0);
            owed_q.push_back(s);
            waves++;
            restart();
         end
      endfunction

      function void field_check(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(wave_summary_type got);
         wave_summary_type want;
         if (owed_q.size() == 0) begin
            $error("result word with no waveform outstanding");
            errors++;
            return;
         end
         want = owed_q.pop_front();
         checked++;
         field_check("peak_amplitude_q4", want.amp,   got.amp);
         field_check("peak_tick",         want.tick,  got.tick);
         field_check("peak_found",        want.found, got.found);
         field_check("noise_rms_q4",      want.rms,   got.rms);
         field_check("noise_count",       want.count, got.count);
         field_check("noise_valid",       want.valid, got.valid);
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [ADC_BITS-1:0]        req_adc_sample;
   logic                       req_last_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_peak_amplitude_q4;
   logic [TICK_W-1:0]          rsp_peak_tick;
   logic                       rsp_peak_found;
   logic [RMS_W-1:0]           rsp_noise_rms_q4;
   logic [CNT_W-1:0]           rsp_noise_count;
   logic                       rsp_noise_valid;
   logic                       csr_write_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CFG_W-1:0]           csr_wdata;

   wave_scoreboard sb;
   int             send_idle_pct = 6;   // chance per cycle that the sender holds back
   int             stall_pct     = 67;  // chance per cycle that the receiver stalls
   int             hold_request  = 0;   // long receiver hold, picked up by its process
   int             reg_writes    = 0;
   int             cycle_count   = 0;

   waveform_peak_and_noise_rms_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_adc_sample        (req_adc_sample),
      .req_last_sample       (req_last_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_peak_amplitude_q4 (rsp_peak_amplitude_q4),
      .rsp_peak_tick         (rsp_peak_tick),
      .rsp_peak_found        (rsp_peak_found),
      .rsp_noise_rms_q4      (rsp_noise_rms_q4),
      .rsp_noise_count       (rsp_noise_count),
      .rsp_noise_valid       (rsp_noise_valid),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
                sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Both handshakes are sampled at the rising edge; inputs only move at the falling one.
   always @(posedge clock) begin : watch
      wave_summary_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_sample(req_adc_sample, req_last_sample);
         if (rsp_valid && !rsp_stall) begin
            got.amp   = rsp_peak_amplitude_q4;
            got.tick  = rsp_peak_tick;
            got.found = rsp_peak_found;
            got.rms   = rsp_noise_rms_q4;
            got.count = rsp_noise_count;
            got.valid = rsp_noise_valid;
            sb.check_result(got);
         end
      end
   end

   // Receiver: random stalls, or a long hold when one is requested.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Offer one sample word; returns at the edge that takes it.
   task automatic send_word(input logic [ADC_BITS-1:0] adc, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_adc_sample  <= adc;
      req_last_sample <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // Sample near the pedestal (mostly noise), a pulse above it, or anything at all.
   function automatic logic [ADC_BITS-1:0] pick_sample();
      int base;
      int spread;
      int val;
      base   = sb.pedestal >> 4;
      spread = (sb.threshold >> 4) + 2;
      case ($urandom_range(9))
         0, 1: val = $urandom_range(0, ADC_MAX);
         2:    val = base + int'($urandom_range(0, 3000));
         default: val = base + int'($urandom_range(0, 2 * spread)) - spread;
      endcase
      if (val < 0)
         val = 0;
      if (val > ADC_MAX)
         val = ADC_MAX;
      return val[ADC_BITS-1:0];
   endfunction

   task automatic send_wave(input int len);
      int i;
      for (i = 0; i < len; i++)
         send_word(pick_sample(), i == len - 1);
   endtask

   // Sender goes quiet until every owed result is back, then lets the core settle.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (LATENCY_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      sb.set_reg(idx, value);
      reg_writes++;
   endtask

   // Registers only change with the core idle.
   task automatic program_regs(input int ped, input int thr, input int first,
                               input int last_tick);
      settle();
      write_reg(REG_PEDESTAL,  CFG_W'(ped));
      write_reg(REG_THRESHOLD, CFG_W'(thr));
      write_reg(REG_ROI_START, CFG_W'(first));
      write_reg(REG_ROI_END,   CFG_W'(last_tick));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin : stimulus
      int sent;
      int wave_no;
      int phase;
      int len;
      int ped;
      int thr;
      int first;
      int last_tick;

      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_adc_sample  = '0;
      req_last_sample = 1'b0;
      csr_write_en    = 1'b0;
      csr_index       = REG_PEDESTAL;
      csr_wdata       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: region is tick 0 only, threshold forty counts.
      send_word(ADC_BITS'(0), 1'b1);          // single-sample waveform
      send_word(ADC_BITS'(ADC_MAX), 1'b0);
      send_word(ADC_BITS'(0), 1'b0);
      send_word(ADC_BITS'(40), 1'b1);

      // Start after end, full-scale pedestal and threshold: empty region, all noise.
      program_regs(CFG_MAX, CFG_MAX, TICK_MAX, 0);
      send_word(ADC_BITS'(ADC_MAX), 1'b0);
      send_word(ADC_BITS'(0), 1'b0);
      send_word(ADC_BITS'(5), 1'b1);

      // Region runs past the waveform end; zero threshold; tie on the peak.
      program_regs(0, 0, 2, TICK_MAX);
      send_word(ADC_BITS'(0), 1'b0);
      send_word(ADC_BITS'(100), 1'b0);
      send_word(ADC_BITS'(200), 1'b0);
      send_word(ADC_BITS'(200), 1'b0);
      send_word(ADC_BITS'(0), 1'b1);

      // Pedestal of 1000 counts; only exact pedestal hits count as noise.
      program_regs(16000, 0, 1, 3);
      send_word(ADC_BITS'(1000), 1'b0);
      send_word(ADC_BITS'(999), 1'b0);
      send_word(ADC_BITS'(1001), 1'b0);
      send_word(ADC_BITS'(1001), 1'b0);
      send_word(ADC_BITS'(1000), 1'b0);
      send_word(ADC_BITS'(999), 1'b1);

      // Nothing qualifies as noise and the region is empty.
      program_regs(0, 0, TICK_MAX, 0);
      send_word(ADC_BITS'(7), 1'b0);
      send_word(ADC_BITS'(9), 1'b1);

      // Random waveforms in three pacing modes.
      send_idle_pct = 6;
      stall_pct     = 67;
      sent          = 0;
      wave_no       = 0;
      phase         = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0 && sent >= RANDOM_ITEMS / 3) begin
            phase = 1;
            settle();                     // sender waits out every owed result
            send_idle_pct = 67;
            stall_pct     = 6;
         end
         if (phase == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
            phase         = 2;
            send_idle_pct = 0;
            stall_pct     = 0;
            hold_request  = 400;          // core fills up and must stall its input
            wave_no       = 1;
         end
         if (wave_no % 3 == 0) begin
            case ($urandom_range(9))
               0:       ped = 0;
               1:       ped = CFG_MAX;
               default: ped = $urandom_range(0, CFG_MAX);
            endcase
            case ($urandom_range(9))
               0:       thr = 0;
               1:       thr = CFG_MAX;
               2, 3:    thr = THR_RESET;
               default: thr = $urandom_range(1, 6000);
            endcase
            case ($urandom_range(9))
               0:       first = TICK_MAX;
               1:       first = 0;
               default: first = $urandom_range(0, 40);
            endcase
            case ($urandom_range(9))
               0:       last_tick = TICK_MAX;
               1:       last_tick = 0;
               default: last_tick = $urandom_range(0, 50);
            endcase
            program_regs(ped, thr, first, last_tick);
         end
         case ($urandom_range(19))
            0:       len = 1;
            1:       len = $urandom_range(60, 120);
            default: len = $urandom_range(2, 40);
         endcase
         send_wave(len);
         sent += len;
         wave_no++;
      end

      settle();
      $display("Checked %0d result words from %0d samples in %0d waveforms, %0d register writes.",
               sb.checked, sb.samples, sb.waves, reg_writes);
      $display("Covered empty and inverted regions, region past the end, full-scale settings, three pacing modes and a long result hold.");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
